@@ rtl/csf_pkg.sv @@
// shared types and constants for the clock scale factor block
package csf_pkg;

    localparam int unsigned FREQ_W = 64;
    localparam int unsigned MUL_W  = 32;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned CNT_W  = 5;

    localparam logic [FREQ_W-1:0] NS_PER_SEC  = 64'd1000000000;
    localparam logic [FREQ_W-1:0] Y_LIMIT     = 64'h0000_0000_8000_0000;
    localparam logic [EXP_W-1:0]  START_EXPO  = 8'sd32;
    localparam int unsigned       TOP_BIT     = 63;
    localparam logic [CNT_W-1:0]  LAST_STEP   = 5'd31;

    typedef struct packed {
        logic [FREQ_W-1:0] x;
        logic [MUL_W-1:0]  y;
        logic [EXP_W-1:0]  expo;
        logic              invalid;
    } csf_norm_t;

endpackage

@@ rtl/csf_norm.sv @@
// normalization of the ratio x/y, one shift per cycle
module csf_norm
    import csf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] tick_frequency,
    output logic              norm_valid,
    input  logic              norm_ready,
    output csf_norm_t         norm
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHRINK_Y,
        ST_GROW_X,
        ST_RAISE,
        ST_FIT,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [FREQ_W-1:0] x_reg;
    logic [FREQ_W-1:0] y_reg;
    logic [EXP_W-1:0]  expo_reg;
    logic              invalid_reg;

    logic [FREQ_W-1:0] y_sh31;
    logic [FREQ_W-1:0] y_sh32;

    assign y_sh31 = y_reg << 31;
    assign y_sh32 = y_reg << 32;

    assign in_ready   = (state_reg == ST_IDLE);
    assign norm_valid = (state_reg == ST_DONE);
    assign norm.x       = x_reg;
    assign norm.y       = y_reg[MUL_W-1:0];
    assign norm.expo    = expo_reg;
    assign norm.invalid = invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            expo_reg    <= '0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg       <= NS_PER_SEC;
                        y_reg       <= tick_frequency;
                        expo_reg    <= START_EXPO;
                        invalid_reg <= (tick_frequency == '0);
                        state_reg   <= (tick_frequency == '0) ? ST_DONE : ST_SHRINK_Y;
                    end
                end
                ST_SHRINK_Y:
                begin
                    if (y_reg >= Y_LIMIT)
                    begin
                        y_reg    <= y_reg >> 1;
                        expo_reg <= expo_reg - 8'd1;
                    end
                    else
                    begin
                        state_reg <= ST_GROW_X;
                    end
                end
                ST_GROW_X:
                begin
                    if ((x_reg < y_sh31) && !x_reg[TOP_BIT])
                    begin
                        x_reg    <= x_reg << 1;
                        expo_reg <= expo_reg - 8'd1;
                    end
                    else
                    begin
                        state_reg <= ST_RAISE;
                    end
                end
                ST_RAISE:
                begin
                    if (x_reg < y_reg)
                    begin
                        y_reg    <= y_reg >> 1;
                        expo_reg <= expo_reg + 8'd1;
                    end
                    else
                    begin
                        state_reg <= ST_FIT;
                    end
                end
                ST_FIT:
                begin
                    if (x_reg >= y_sh32)
                    begin
                        x_reg    <= x_reg >> 1;
                        expo_reg <= expo_reg + 8'd1;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (norm_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/csf_div.sv @@
// restoring 64 by 32 division, one quotient bit per cycle, with output register
module csf_div
    import csf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             norm_valid,
    output logic             norm_ready,
    input  csf_norm_t        norm,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [MUL_W-1:0] multiplier,
    output logic [EXP_W-1:0] shift_amount,
    output logic             freq_invalid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [MUL_W-1:0] rem_reg;
    logic [MUL_W-1:0] quo_reg;
    logic [MUL_W-1:0] den_reg;
    logic [EXP_W-1:0] expo_reg;
    logic             invalid_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [MUL_W-1:0] trial;
    logic             fits;

    assign trial = {rem_reg[MUL_W-2:0], quo_reg[MUL_W-1]};
    assign fits  = (trial >= den_reg);

    assign norm_ready   = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_DONE);
    assign multiplier   = quo_reg;
    assign shift_amount = expo_reg;
    assign freq_invalid = invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rem_reg     <= '0;
            quo_reg     <= '0;
            den_reg     <= '0;
            expo_reg    <= '0;
            invalid_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (norm_valid)
                    begin
                        cnt_reg     <= '0;
                        den_reg     <= norm.y;
                        invalid_reg <= norm.invalid;
                        if (norm.invalid)
                        begin
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            expo_reg  <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            rem_reg   <= norm.x[FREQ_W-1:MUL_W];
                            quo_reg   <= norm.x[MUL_W-1:0];
                            expo_reg  <= norm.expo;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    rem_reg <= fits ? (trial - den_reg) : trial;
                    quo_reg <= {quo_reg[MUL_W-2:0], fits};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/clock_scale_factor.sv @@
// top level of the clock scale factor block
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | tick_frequency
//  out     | out_valid/out_ready | multiplier, shift_amount, freq_invalid
//
// normalization shifts x or y one bit at a time over its passes: shrink y, grow x, raise, fit
// the divider produces the 32 quotient bits one at a time; zero frequency skips both
// normalizer and divider run one beat each, so the next beat can normalize
// while a finished result waits in the output register
// rst_n clears all control state asynchronously
module clock_scale_factor
    import csf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] tick_frequency,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MUL_W-1:0]  multiplier,
    output logic signed [EXP_W-1:0] shift_amount,
    output logic              freq_invalid
);

    logic      norm_valid;
    logic      norm_ready;
    csf_norm_t norm;
    logic [EXP_W-1:0] shift_bits;

    csf_norm u_norm (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .tick_frequency (tick_frequency),
        .norm_valid     (norm_valid),
        .norm_ready     (norm_ready),
        .norm           (norm)
    );

    csf_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .norm_valid   (norm_valid),
        .norm_ready   (norm_ready),
        .norm         (norm),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .multiplier   (multiplier),
        .shift_amount (shift_bits),
        .freq_invalid (freq_invalid)
    );

    assign shift_amount = $signed(shift_bits);

endmodule

@@ rtl/csf_check.sv @@
// port-level checks for the clock scale factor block, bound to the top level
module csf_check
    import csf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [FREQ_W-1:0] tick_frequency,
    input logic              out_valid,
    input logic              out_ready,
    input logic [MUL_W-1:0]  multiplier,
    input logic signed [EXP_W-1:0] shift_amount,
    input logic              freq_invalid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(multiplier)
            && $stable(shift_amount) && $stable(freq_invalid))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && freq_invalid |-> multiplier == '0 && shift_amount == '0)
        else $error("invalid result with nonzero fields");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_zero_freq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && tick_frequency != '0 |=> !(out_valid && $rose(out_valid)
            && freq_invalid))
        else $error("invalid flag on nonzero frequency");

endmodule

bind clock_scale_factor csf_check u_csf_check (.*);
